### rtl/hpvt_pkg.sv
// Shared types and constants for the homogeneous point/vector transform.
// No dependencies; the top module of the block imports this package.
package hpvt_pkg;

    localparam int DW = 32;

    typedef enum logic [2:0] {
        OP_LOAD_FWD = 3'd0,
        OP_LOAD_INV = 3'd1,
        OP_POINT    = 3'd2,
        OP_DIR      = 3'd3,
        OP_NORMAL   = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [2:0]           opcode;
        logic [1:0]           row;
        logic [1:0]           col;
        logic signed [DW-1:0] entry_value;
        logic signed [DW-1:0] in_x;
        logic signed [DW-1:0] in_y;
        logic signed [DW-1:0] in_z;
    } in_t;

    typedef struct packed {
        logic signed [DW-1:0] out_x;
        logic signed [DW-1:0] out_y;
        logic signed [DW-1:0] out_z;
        logic                 zero_w;
        logic                 overflow;
    } out_t;

endpackage

### rtl/hpvt_div_cell.sv
// One restoring-division cell: settles one quotient bit and passes the
// partial remainder on. Depends on nothing; instantiated in a chain by the top.
module hpvt_div_cell #(
    parameter int NW   = 117,
    parameter int DDW  = 67,
    parameter int QW   = 32,
    parameter int STEP = 0
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [NW-1:0]   n_in,
    input  logic [DDW-1:0]  d_in,
    input  logic [QW-1:0]   q_in,
    output logic [NW-1:0]   n_out,
    output logic [DDW-1:0]  d_out,
    output logic [QW-1:0]   q_out
);
    logic [NW-1:0]  n_reg, n_next, shifted;
    logic [DDW-1:0] d_reg;
    logic [QW-1:0]  q_reg, q_next;
    logic           ge;

    always_comb begin
        shifted = NW'(d_in) << STEP;
        ge      = (n_in >= shifted);
        n_next  = ge ? (n_in - shifted) : n_in;
        q_next  = q_in;
        q_next[STEP] = ge;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= n_next;
            d_reg <= d_in;
            q_reg <= q_next;
        end
    end

    assign n_out = n_reg;
    assign d_out = d_reg;
    assign q_out = q_reg;
endmodule

### rtl/homogeneous_point_vector_transform.sv
// Top level of the homogeneous point/vector transform; depends on hpvt_pkg and hpvt_div_cell.
// Pipeline: four datapath stages, 32 division cells and the output register lie between
// an input beat and its result beat.
// Throughput: one beat per cycle; the whole pipeline holds while the result waits.
// Reset (aresetn low, synchronous) empties the pipeline and sets both
// matrices to the identity.
module homogeneous_point_vector_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hpvt_pkg::in_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output hpvt_pkg::out_t m_data
);
    import hpvt_pkg::*;

    localparam int W  = DW;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 3;
    localparam int CW = AW + W + F;

    // Sideband that walks beside the division cells.
    typedef struct packed {
        logic                valid;
        logic                divide;
        logic                zero_w;
        logic [2:0][W-1:0]   res;
        logic [2:0]          ovf;
        logic [2:0]          dovf;
        logic [2:0]          dneg;
    } side_t;

    // The whole pipeline moves when the output register is free or drained.
    logic en;
    logic accept;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign accept  = s_valid && en;

    // Matrix storage; loads land at their accept edge, so the very next
    // transform beat already sees the new entry.
    logic signed [W-1:0] fwd_reg [4][4];
    logic signed [W-1:0] inv_reg [4][4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    fwd_reg[r][c] <= (r == c) ? W'(1 << F) : '0;
                    inv_reg[r][c] <= (r == c) ? W'(1 << F) : '0;
                end
            end
        end else if (accept) begin
            if (s_data.opcode == OP_LOAD_FWD) begin
                fwd_reg[s_data.row][s_data.col] <= s_data.entry_value;
            end
            if (s_data.opcode == OP_LOAD_INV) begin
                inv_reg[s_data.row][s_data.col] <= s_data.entry_value;
            end
        end
    end

    // Stage 1: pick coefficients. Normals use the transposed inverse.
    logic                valid1_reg;
    logic                point1_reg;
    logic signed [W-1:0] coef1_reg [4][3];
    logic signed [W-1:0] trans1_reg [4];
    logic signed [W-1:0] v1_reg [3];
    logic                is_xform;

    assign is_xform = (s_data.opcode == OP_POINT) || (s_data.opcode == OP_DIR) ||
                      (s_data.opcode == OP_NORMAL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= s_valid && is_xform;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            point1_reg <= (s_data.opcode == OP_POINT);
            v1_reg[0]  <= s_data.in_x;
            v1_reg[1]  <= s_data.in_y;
            v1_reg[2]  <= s_data.in_z;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    coef1_reg[r][c] <= (s_data.opcode == OP_NORMAL) ? inv_reg[c][r]
                                                                    : fwd_reg[r][c];
                end
                trans1_reg[r] <= (s_data.opcode == OP_POINT) ? fwd_reg[r][3] : '0;
            end
        end
    end

    // Stage 2: twelve products, each registered.
    logic                 valid2_reg, point2_reg;
    logic signed [PW-1:0] prod2_reg [4][3];
    logic signed [AW-1:0] trans2_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            point2_reg <= point1_reg;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod2_reg[r][c] <= coef1_reg[r][c] * v1_reg[c];
                end
                trans2_reg[r] <= AW'(trans1_reg[r]) <<< F;
            end
        end
    end

    // Stage 3: exact sums in Q(2F).
    logic                 valid3_reg, point3_reg;
    logic signed [AW-1:0] acc3_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid3_reg <= 1'b0;
        end else if (en) begin
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            point3_reg <= point2_reg;
            for (int r = 0; r < 4; r++) begin
                acc3_reg[r] <= AW'(prod2_reg[r][0]) + AW'(prod2_reg[r][1]) +
                               AW'(prod2_reg[r][2]) + trans2_reg[r];
            end
        end
    end

    // Stage 4: classify w, round the no-divide cases and prepare the divide.
    logic                 w_one, w_zero, do_div;
    logic signed [AW-1:0] rnd [3];
    logic [AW-1:0]        mag [3];
    logic [AW-1:0]        wmag;
    logic [CW-1:0]        num [3];
    side_t                side4_next, side4_reg;
    logic [CW-1:0]        n0_reg [3];
    logic [AW-1:0]        d0_reg;
    logic [CW-1:0]        cn [3][W+1];
    logic [AW-1:0]        cd [3][W+1];
    logic [W-1:0]         cq [3][W+1];

    always_comb begin
        w_one  = (acc3_reg[3] == (AW'(1) <<< (2 * F)));
        w_zero = (acc3_reg[3] == '0);
        do_div = point3_reg && !w_one && !w_zero;
        wmag   = acc3_reg[3][AW-1] ? AW'(-acc3_reg[3]) : AW'(acc3_reg[3]);
        side4_next        = '0;
        side4_next.valid  = valid3_reg;
        side4_next.divide = do_div;
        side4_next.zero_w = point3_reg && w_zero;
        for (int r = 0; r < 3; r++) begin
            rnd[r] = (acc3_reg[r] + (AW'(1) <<< (F - 1))) >>> F;
            mag[r] = acc3_reg[r][AW-1] ? AW'(-acc3_reg[r]) : AW'(acc3_reg[r]);
            num[r] = CW'(mag[r]) << F;
            side4_next.dneg[r] = acc3_reg[r][AW-1] ^ acc3_reg[3][AW-1];
            side4_next.dovf[r] = (num[r] >= (CW'(wmag) << W));
            if (point3_reg && w_zero) begin
                side4_next.ovf[r] = 1'b1;
                side4_next.res[r] = acc3_reg[r][AW-1] ? {1'b1, {(W-1){1'b0}}}
                                                      : {1'b0, {(W-1){1'b1}}};
            end else if (rnd[r][AW-1:W-1] == '0 || rnd[r][AW-1:W-1] == '1) begin
                side4_next.ovf[r] = 1'b0;
                side4_next.res[r] = rnd[r][W-1:0];
            end else begin
                side4_next.ovf[r] = 1'b1;
                side4_next.res[r] = rnd[r][AW-1] ? {1'b1, {(W-1){1'b0}}}
                                                 : {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side4_reg.valid <= 1'b0;
        end else if (en) begin
            side4_reg <= side4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d0_reg <= wmag;
            for (int r = 0; r < 3; r++) begin
                n0_reg[r] <= num[r];
            end
        end
    end

    // Division chain: cell k settles quotient bit W-1-k for each coordinate.
    // The quotient overflow check above guarantees W bits are enough.
    for (genvar r = 0; r < 3; r++) begin : g_lane
        assign cn[r][0] = n0_reg[r];
        assign cd[r][0] = d0_reg;
        assign cq[r][0] = '0;
        for (genvar k = 0; k < W; k++) begin : g_cell
            hpvt_div_cell #(
                .NW  (CW),
                .DDW (AW),
                .QW  (W),
                .STEP(W - 1 - k)
            ) u_cell (
                .aclk (aclk),
                .en   (en),
                .n_in (cn[r][k]),
                .d_in (cd[r][k]),
                .q_in (cq[r][k]),
                .n_out(cn[r][k+1]),
                .d_out(cd[r][k+1]),
                .q_out(cq[r][k+1])
            );
        end
    end

    // Sideband shift line, aligned with the cell outputs.
    side_t side_reg [W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < W; k++) begin
                side_reg[k].valid <= 1'b0;
            end
        end else if (en) begin
            side_reg[0] <= side4_reg;
            for (int k = 1; k < W; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Final stage: apply the quotient sign and saturate, then the output register.
    side_t         last;
    logic [W-1:0]  fin [3];
    logic [2:0]    fov;
    logic [W-1:0]  qv;
    logic          sat;
    out_t          out_next, out_reg;
    logic          out_valid_reg;

    assign last = side_reg[W-1];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            qv  = cq[r][W];
            sat = last.dovf[r] ||
                  (!last.dneg[r] && qv[W-1]) ||
                  (last.dneg[r] && (qv > {1'b1, {(W-1){1'b0}}}));
            if (!last.divide) begin
                fin[r] = last.res[r];
                fov[r] = last.ovf[r];
            end else if (sat) begin
                fin[r] = last.dneg[r] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                fov[r] = 1'b1;
            end else begin
                fin[r] = last.dneg[r] ? W'(-qv) : qv;
                fov[r] = 1'b0;
            end
        end
        out_next.out_x    = fin[0];
        out_next.out_y    = fin[1];
        out_next.out_z    = fin[2];
        out_next.zero_w   = last.zero_w;
        out_next.overflow = |fov;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // A zero w always saturates, so the flag implies overflow.
    a_zero_w_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_w |-> m_data.overflow)
        else $error("zero_w without overflow");

    // With a zero w every coordinate sits at one of the two limits; the check covers out_x.
    a_zero_w_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_w |->
            (m_data.out_x == {1'b1, {(W-1){1'b0}}} ||
             m_data.out_x == {1'b0, {(W-1){1'b1}}}))
        else $error("zero_w result not saturated");

    // A held result freezes the whole pipeline, input side included.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
endmodule
